FILE: design/vcsl_pkg.sv
// Shared constants, register indexes and lane control types for the
// velocity command slew limiter. No dependencies.
package vcsl_pkg;

	localparam int AXES = 3;
	localparam int AX_X = 0;
	localparam int AX_Y = 1;
	localparam int AX_YAW = 2;

	localparam int VEL_W = 32;   // velocity / acceleration word
	localparam int LIM_W = 31;   // magnitude limit registers
	localparam int DT_W = 20;    // tick length in microseconds
	localparam int TMO_W = 32;   // timeout and time-since-command counter
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam int DIV_STEPS = 32;   // quotient bits per division
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam logic [DT_W-1:0] US_PER_S = DT_W'(1000000);

	localparam logic [LIM_W-1:0] VEL_LIM_RST = LIM_W'(65536);
	localparam logic [LIM_W-1:0] ACC_LIM_RST = LIM_W'(65536);
	localparam logic [TMO_W-1:0] TIMEOUT_RST = TMO_W'(500000);

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MAX_VEL_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_VEL_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_VEL_YAW = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ACC_X = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ACC_Y = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ACC_YAW = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 3'd6;

	// sequencer strobes broadcast to every lane
	typedef struct packed {
		logic accept;
		logic new_command;
		logic timed_out;
		logic clamp;
		logic mult;
		logic div_load;
		logic div_step;
		logic commit;
	} lane_ctl_t;

	typedef struct packed {
		logic signed [VEL_W-1:0] vel;
		logic signed [VEL_W-1:0] acc;
		logic                    sat;
	} lane_res_t;

endpackage

FILE: design/vcsl_if.sv
// Valid/ready channel interfaces for command beats and result beats.
// Depends on vcsl_pkg.
interface vcsl_cmd_if
	import vcsl_pkg::*;
();
	logic                    valid;
	logic                    ready;
	logic                    new_command;
	logic signed [VEL_W-1:0] cmd_x;
	logic signed [VEL_W-1:0] cmd_y;
	logic signed [VEL_W-1:0] cmd_yaw;
	logic [DT_W-1:0]         elapsed_us;

	modport source (output valid, new_command, cmd_x, cmd_y, cmd_yaw, elapsed_us,
		input ready);
	modport sink (input valid, new_command, cmd_x, cmd_y, cmd_yaw, elapsed_us,
		output ready);
endinterface

interface vcsl_res_if
	import vcsl_pkg::*;
();
	logic                    valid;
	logic                    ready;
	logic signed [VEL_W-1:0] vel_x;
	logic signed [VEL_W-1:0] vel_y;
	logic signed [VEL_W-1:0] vel_yaw;
	logic signed [VEL_W-1:0] acc_x;
	logic signed [VEL_W-1:0] acc_y;
	logic signed [VEL_W-1:0] acc_yaw;
	logic                    timed_out;
	logic                    sat_x;
	logic                    sat_y;
	logic                    sat_yaw;

	modport source (output valid, vel_x, vel_y, vel_yaw, acc_x, acc_y, acc_yaw,
		timed_out, sat_x, sat_y, sat_yaw, input ready);
	modport sink (input valid, vel_x, vel_y, vel_yaw, acc_x, acc_y, acc_yaw,
		timed_out, sat_x, sat_y, sat_yaw, output ready);
endinterface

FILE: design/velocity_command_slew_limiter.sv
// Velocity command slew limiter: three lanes, one per axis, share a sequencer.
// Commands are taken only while the sequencer is idle; each beat passes clamp,
// multiply and the 32-step restoring divider in each lane. A finished result
// waits in the output register; the next one waits in the hand-off state.
// Reset (arst_n low, async): limits and timeout to defaults, held commands and
// velocities to zero, command timer all ones, so the block starts timed out.
module velocity_command_slew_limiter
	import vcsl_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	vcsl_cmd_if.sink              cmd,
	vcsl_res_if.source            res
);

	// sequencer states
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CLAMP = 3'd1;
	localparam logic [2:0] ST_MULT = 3'd2;
	localparam logic [2:0] ST_LOAD = 3'd3;
	localparam logic [2:0] ST_DIV = 3'd4;
	localparam logic [2:0] ST_OUT = 3'd5;

	logic [2:0]             state_q;
	logic [DIV_CNT_W-1:0]   cnt_q;

	// configuration
	logic [LIM_W-1:0]       max_vel_q [AXES];
	logic [LIM_W-1:0]       max_acc_q [AXES];
	logic [TMO_W-1:0]       timeout_q;

	// command timer
	logic [TMO_W-1:0]       tsc_q;
	logic [TMO_W:0]         tsc_sum;
	logic [TMO_W-1:0]       tsc_next;
	logic                   timed_q;
	logic [DT_W-1:0]        dt_q;

	logic                   accept;
	logic                   load_out;
	lane_ctl_t              ctl;
	lane_res_t              lane_res [AXES];
	logic signed [VEL_W-1:0] cmd_arr [AXES];

	// output register
	logic                    out_valid_q;
	logic signed [VEL_W-1:0] vel_q [AXES];
	logic signed [VEL_W-1:0] acc_q [AXES];
	logic [AXES-1:0]         sat_q;
	logic                    out_timed_q;

	assign cmd.ready = (state_q == ST_IDLE);
	assign accept = cmd.valid && cmd.ready;
	// result moves to the output register once the previous beat has left
	assign load_out = (state_q == ST_OUT) && (!out_valid_q || res.ready);

	// timer: a new command restarts it, otherwise it saturates at all ones
	always_comb begin
		tsc_sum = {1'b0, tsc_q} + (TMO_W+1)'(cmd.elapsed_us);
		if (cmd.new_command)
			tsc_next = '0;
		else if (tsc_sum[TMO_W])
			tsc_next = '1;
		else
			tsc_next = tsc_sum[TMO_W-1:0];
	end

	// configuration writes; indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < AXES; i++) begin
				max_vel_q[i] <= VEL_LIM_RST;
				max_acc_q[i] <= ACC_LIM_RST;
			end
			timeout_q <= TIMEOUT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MAX_VEL_X: max_vel_q[AX_X] <= cfg_wdata[LIM_W-1:0];
				REG_MAX_VEL_Y: max_vel_q[AX_Y] <= cfg_wdata[LIM_W-1:0];
				REG_MAX_VEL_YAW: max_vel_q[AX_YAW] <= cfg_wdata[LIM_W-1:0];
				REG_MAX_ACC_X: max_acc_q[AX_X] <= cfg_wdata[LIM_W-1:0];
				REG_MAX_ACC_Y: max_acc_q[AX_Y] <= cfg_wdata[LIM_W-1:0];
				REG_MAX_ACC_YAW: max_acc_q[AX_YAW] <= cfg_wdata[LIM_W-1:0];
				REG_TIMEOUT: timeout_q <= cfg_wdata[TMO_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer: clamp, multiply, divider load, divider steps, hand-off
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			tsc_q <= '1;
			timed_q <= 1'b1;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						tsc_q <= tsc_next;
						timed_q <= tsc_next > timeout_q;
						state_q <= ST_CLAMP;
					end
				end
				ST_CLAMP: state_q <= ST_MULT;
				ST_MULT: state_q <= ST_LOAD;
				ST_LOAD: begin
					cnt_q <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1))
						state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (load_out)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			dt_q <= cmd.elapsed_us;
	end

	always_comb begin
		ctl.accept = accept;
		ctl.new_command = cmd.new_command;
		ctl.timed_out = timed_q;
		ctl.clamp = (state_q == ST_CLAMP);
		ctl.mult = (state_q == ST_MULT);
		ctl.div_load = (state_q == ST_LOAD);
		ctl.div_step = (state_q == ST_DIV);
		ctl.commit = load_out;
	end

	assign cmd_arr[AX_X] = cmd.cmd_x;
	assign cmd_arr[AX_Y] = cmd.cmd_y;
	assign cmd_arr[AX_YAW] = cmd.cmd_yaw;

	for (genvar g = 0; g < AXES; g++) begin : g_lane
		vcsl_lane u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.cmd     (cmd_arr[g]),
			.dt      (dt_q),
			.max_vel (max_vel_q[g]),
			.max_acc (max_acc_q[g]),
			.res     (lane_res[g])
		);
	end

	// merge: gather lane results and the shared timeout flag into one beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load_out)
			out_valid_q <= 1'b1;
		else if (res.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			for (int i = 0; i < AXES; i++) begin
				vel_q[i] <= lane_res[i].vel;
				acc_q[i] <= lane_res[i].acc;
				sat_q[i] <= lane_res[i].sat;
			end
			out_timed_q <= timed_q;
		end
	end

	assign res.valid = out_valid_q;
	assign res.vel_x = vel_q[AX_X];
	assign res.vel_y = vel_q[AX_Y];
	assign res.vel_yaw = vel_q[AX_YAW];
	assign res.acc_x = acc_q[AX_X];
	assign res.acc_y = acc_q[AX_Y];
	assign res.acc_yaw = acc_q[AX_YAW];
	assign res.timed_out = out_timed_q;
	assign res.sat_x = sat_q[AX_X];
	assign res.sat_y = sat_q[AX_Y];
	assign res.sat_yaw = sat_q[AX_YAW];

endmodule

FILE: design/vcsl_div.sv
// Restoring divider, one quotient bit per step, fixed quotient width.
// Flags overflow when the quotient does not fit. No package dependency.
module vcsl_div #(
	parameter int DW = 52,
	parameter int QW = 32,
	parameter int VW = 20
) (
	input  logic          clk,
	input  logic          load,
	input  logic          step,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic [QW-1:0] quotient,
	output logic          ovf
);

	localparam int HW = DW - QW;
	localparam int CW = (HW > VW) ? HW : VW;

	logic [VW-1:0] rem_q;
	logic [QW-1:0] quo_q;
	logic [VW-1:0] dvs_q;
	logic          ovf_q;
	logic [HW-1:0] hi;
	logic [VW:0]   trial;
	logic [VW+1:0] diff;
	logic          ge;

	assign hi = dividend[DW-1:QW];
	assign trial = {rem_q, quo_q[QW-1]};
	assign diff = {1'b0, trial} - {2'b00, dvs_q};
	assign ge = ~diff[VW+1];

	always_ff @(posedge clk) begin
		if (load) begin
			rem_q <= VW'(hi);
			quo_q <= dividend[QW-1:0];
			dvs_q <= divisor;
			ovf_q <= CW'(hi) >= CW'(divisor);
		end else if (step) begin
			rem_q <= ge ? diff[VW-1:0] : trial[VW-1:0];
			quo_q <= {quo_q[QW-2:0], ge};
		end
	end

	assign quotient = quo_q;
	assign ovf = ovf_q;

endmodule

FILE: design/vcsl_lane.sv
// One axis: held command, velocity clamp, slew limit and acceleration.
// Depends on vcsl_pkg and vcsl_div.
module vcsl_lane
	import vcsl_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  lane_ctl_t               ctl,
	input  logic signed [VEL_W-1:0] cmd,
	input  logic [DT_W-1:0]         dt,
	input  logic [LIM_W-1:0]        max_vel,
	input  logic [LIM_W-1:0]        max_acc,
	output lane_res_t               res
);

	localparam int PW = LIM_W + DT_W;      // max_acc * dt
	localparam int NW = VEL_W + DT_W;      // |diff| * 1e6

	// limit = floor(max_acc * dt / 1e6): 1e6 = 2^6 * 15625, so shift out the
	// 2^6, then multiply by a rounded-up reciprocal of 15625. The error term
	// stays under 2^-14 of the divisor, exact for any 45-bit operand.
	localparam int LIM_SH = 6;
	localparam longint unsigned LIM_ODD = 15625;
	localparam int LIM_ODD_W = 14;         // 2^14 >= 15625
	localparam int YW = PW - LIM_SH;       // operand after the shift
	localparam int RW = YW + 1;            // reciprocal width
	localparam int RK = YW + LIM_ODD_W;    // reciprocal scale 2^RK
	localparam int AW = YW + RW;           // full product width
	localparam int YS = 15;                // operand slice per row
	localparam int MS = 23;                // reciprocal half
	localparam int YN = YW / YS;           // rows of partial products
	localparam logic [RW-1:0] RCP = RW'(((64'd1 << RK) + LIM_ODD - 64'd1) / LIM_ODD);

	logic signed [VEL_W-1:0] held_q;
	logic signed [VEL_W-1:0] prev_q;
	logic                    sat_q;

	logic                    neg_s1;
	logic [VEL_W-1:0]        mag_s1;
	logic [PW-1:0]           prod_s2;
	logic [NW-1:0]           num_s2;

	logic signed [VEL_W:0]   cmd33;
	logic signed [VEL_W:0]   mv33;
	logic signed [VEL_W:0]   target;
	logic signed [VEL_W:0]   diff;
	logic                    sat_d;

	logic [YW-1:0]           rcp_y_q;
	logic [AW-1:0]           rcp_acc_q;
	logic [1:0]              rcp_row_q;
	logic                    rcp_col_q;
	logic [MS-1:0]           rcp_m;
	logic [YS+MS-1:0]        rcp_pp;

	logic [VEL_W-1:0]        acc_quo;
	logic                    acc_ovf;
	logic [VEL_W-1:0]        limit;
	logic [VEL_W-1:0]        dmag;
	logic signed [VEL_W:0]   delta;
	logic [VEL_W:0]          vel_sum;
	logic [VEL_W-1:0]        qmax;
	logic [VEL_W-1:0]        qsat;

	// clamp held command against velocity limit, or target zero when timed out
	always_comb begin
		cmd33 = {held_q[VEL_W-1], held_q};
		mv33 = signed'({2'b00, max_vel});
		target = '0;
		sat_d = sat_q;
		if (!ctl.timed_out) begin
			if (cmd33 > mv33) begin
				target = mv33;
				sat_d = 1'b1;
			end else if (cmd33 < -mv33) begin
				target = -mv33;
				sat_d = 1'b1;
			end else begin
				target = cmd33;
				sat_d = 1'b0;
			end
		end
		diff = target - {prev_q[VEL_W-1], prev_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			prev_q <= '0;
			sat_q <= 1'b0;
		end else begin
			if (ctl.accept && ctl.new_command)
				held_q <= cmd;
			if (ctl.clamp)
				sat_q <= sat_d;
			if (ctl.commit)
				prev_q <= res.vel;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.clamp) begin
			neg_s1 <= diff[VEL_W];
			mag_s1 <= diff[VEL_W] ? VEL_W'(-diff) : VEL_W'(diff);
		end
		if (ctl.mult) begin
			prod_s2 <= PW'(max_acc) * PW'(dt);
			num_s2 <= NW'(mag_s1) * NW'(US_PER_S);
		end
	end

	// reciprocal product, one 15x23 partial product per step: six steps,
	// done long before the acceleration divider finishes
	always_comb begin
		rcp_m = rcp_col_q ? RCP[RW-1:MS] : RCP[MS-1:0];
		rcp_pp = (YS+MS)'(rcp_y_q[YS-1:0]) * (YS+MS)'(rcp_m);
	end

	always_ff @(posedge clk) begin
		if (ctl.div_load) begin
			rcp_y_q <= prod_s2[PW-1:LIM_SH];
			rcp_acc_q <= '0;
			rcp_row_q <= '0;
			rcp_col_q <= 1'b0;
		end else if (ctl.div_step && rcp_row_q != 2'(YN)) begin
			rcp_acc_q <= rcp_acc_q + (AW'(rcp_pp) << (YS * rcp_row_q + MS * rcp_col_q));
			rcp_col_q <= ~rcp_col_q;
			if (rcp_col_q) begin
				rcp_row_q <= rcp_row_q + 1'b1;
				rcp_y_q <= rcp_y_q >> YS;
			end
		end
	end

	// acc = |diff| * 1e6 / dt
	vcsl_div #(.DW(NW), .QW(VEL_W), .VW(DT_W)) u_acc_div (
		.clk      (clk),
		.load     (ctl.div_load),
		.step     (ctl.div_step),
		.dividend (num_s2),
		.divisor  (dt),
		.quotient (acc_quo),
		.ovf      (acc_ovf)
	);

	always_comb begin
		limit = rcp_acc_q[RK +: VEL_W];
		dmag = (mag_s1 > limit) ? limit : mag_s1;
		delta = neg_s1 ? -signed'({1'b0, dmag}) : signed'({1'b0, dmag});
		vel_sum = {prev_q[VEL_W-1], prev_q} + delta;
		qmax = {1'b0, max_acc};
		qsat = (acc_ovf || acc_quo > qmax) ? qmax : acc_quo;
		res.vel = signed'(vel_sum[VEL_W-1:0]);
		if (dt == '0)
			res.acc = '0;
		else
			res.acc = neg_s1 ? -signed'(qsat) : signed'(qsat);
		res.sat = sat_q;
	end

endmodule

FILE: bench/tb_top.sv
// Self-checking bench for velocity_command_slew_limiter: command and result
// channels, config port, cycle-free predictor and scoreboard.
// Depends on vcsl_pkg, vcsl_cmd_if, vcsl_res_if and the block itself.
module tb_top;
	import vcsl_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// index 7 decodes to nothing; writes there must leave every limit alone
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam longint MICROS = 1000000;
	localparam int NUM_PHASES = 6;
	localparam int TICKS_PER_PHASE = 275;
	localparam int HOLD_CYCLES = 800;

	// one command beat as the sender sees it
	typedef struct packed {
		logic                           new_command;
		logic [AXES-1:0][VEL_W-1:0]     cmd;
		logic [DT_W-1:0]                elapsed_us;
	} tick_t;

	// one result beat
	typedef struct packed {
		logic [AXES-1:0][VEL_W-1:0] vel;
		logic [AXES-1:0][VEL_W-1:0] acc;
		logic                       timed_out;
		logic [AXES-1:0]            sat;
	} motion_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	vcsl_cmd_if cmd_if ();
	vcsl_res_if res_if ();

	velocity_command_slew_limiter DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.cmd(cmd_if),
		.res(res_if)
	);

	// ---------------------------------------------------------------
	// Predictor state: a private copy of the limits and of the
	// block's memory (held command, last velocity, clamp flags, timer).
	// ---------------------------------------------------------------
	logic [AXES-1:0][LIM_W-1:0] lim_vel;
	logic [AXES-1:0][LIM_W-1:0] lim_acc;
	logic [TMO_W-1:0]           tmo;
	logic [AXES-1:0][VEL_W-1:0] held_cmd;
	logic [AXES-1:0][VEL_W-1:0] prev_vel;
	logic [AXES-1:0]            sat_flags;
	logic [TMO_W-1:0]           since_cmd;

	tick_t   pending[$];      // beats waiting for the sender
	motion_t expected_q[$];   // predicted results, oldest first
	tick_t   on_wire;         // beat currently offered on the command channel

	int n_sent = 0;           // beats handed to the sender
	int n_done = 0;           // result beats received
	int n_err = 0;
	int tx_gap = 0;
	int rx_gap = 0;
	bit idle_on = 1'b1;       // random gaps on both channels
	bit hold_go = 1'b0;       // request for the long receiver hold-off
	logic rx_hold = 1'b0;

	string axis_tag [AXES] = '{"x", "y", "yaw"};

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Gap length for either side: mostly none or short, now and then long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!idle_on || r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// One control tick of the limiter. Updates the predictor state and
	// returns the result beat the block must produce for this tick.
	function automatic motion_t slew_step(input tick_t t);
		motion_t r;
		longint tgt, prv, diff, mag, step_lim, delta, vel, rate;
		longint unsigned sum;
		int i;
		r = '0;
		// a fresh command restarts the timer; otherwise it counts up and
		// sticks at all ones
		if (t.new_command) begin
			held_cmd = t.cmd;
			since_cmd = '0;
		end else begin
			sum = longint'(since_cmd) + longint'(t.elapsed_us);
			since_cmd = (sum > 64'hFFFF_FFFF) ? '1 : sum[TMO_W-1:0];
		end
		r.timed_out = since_cmd > tmo;
		for (i = 0; i < AXES; i++) begin
			tgt = 0;
			prv = longint'($signed(prev_vel[i]));
			// timed out: target zero, clamp flags keep their last value
			if (!r.timed_out) begin
				tgt = longint'($signed(held_cmd[i]));
				if (tgt > longint'(lim_vel[i])) begin
					tgt = longint'(lim_vel[i]);
					sat_flags[i] = 1'b1;
				end else if (tgt < -longint'(lim_vel[i])) begin
					tgt = -longint'(lim_vel[i]);
					sat_flags[i] = 1'b1;
				end else begin
					sat_flags[i] = 1'b0;
				end
			end
			diff = tgt - prv;
			mag = (diff < 0) ? -diff : diff;
			// largest change this tick: floor(max_acc * dt / 1 s)
			step_lim = longint'(lim_acc[i]) * longint'(t.elapsed_us) / MICROS;
			if (mag > step_lim)
				delta = (diff < 0) ? -step_lim : step_lim;
			else
				delta = diff;
			vel = prv + delta;
			// reported rate uses the full wanted change, then clamps;
			// a zero-length tick reports no rate
			if (t.elapsed_us == '0) begin
				rate = 0;
			end else begin
				rate = mag * MICROS / longint'(t.elapsed_us);
				if (rate > longint'(lim_acc[i]))
					rate = longint'(lim_acc[i]);
				if (diff < 0)
					rate = -rate;
			end
			prev_vel[i] = vel[VEL_W-1:0];
			r.vel[i] = vel[VEL_W-1:0];
			r.acc[i] = rate[VEL_W-1:0];
		end
		r.sat = sat_flags;
		return r;
	endfunction

	task automatic check_beat(input motion_t want, input motion_t got);
		int i;
		for (i = 0; i < AXES; i++) begin
			if (got.vel[i] !== want.vel[i]) begin
				$error("vel_%s: expected %0d, got %0d", axis_tag[i],
					$signed(want.vel[i]), $signed(got.vel[i]));
				n_err++;
			end
			if (got.acc[i] !== want.acc[i]) begin
				$error("acc_%s: expected %0d, got %0d", axis_tag[i],
					$signed(want.acc[i]), $signed(got.acc[i]));
				n_err++;
			end
			if (got.sat[i] !== want.sat[i]) begin
				$error("sat_%s: expected %0b, got %0b", axis_tag[i],
					want.sat[i], got.sat[i]);
				n_err++;
			end
		end
		if (got.timed_out !== want.timed_out) begin
			$error("timed_out: expected %0b, got %0b", want.timed_out, got.timed_out);
			n_err++;
		end
	endtask

	// ---------------------------------------------------------------
	// Command driver. Pops the next beat once the current one is taken
	// (or none is up), with random gaps between beats. The prediction is
	// made at the edge where the beat is accepted.
	// ---------------------------------------------------------------
	always @(posedge clk) begin : command_driver
		if (!arst_n) begin
			cmd_if.valid <= 1'b0;
			tx_gap <= 0;
		end else begin
			if (cmd_if.valid && cmd_if.ready)
				expected_q.insert(expected_q.size(), slew_step(on_wire));
			if (!cmd_if.valid || cmd_if.ready) begin
				if (tx_gap != 0) begin
					tx_gap <= tx_gap - 1;
					cmd_if.valid <= 1'b0;
				end else if (pending.size() != 0) begin
					on_wire = pending.pop_front();
					cmd_if.new_command <= on_wire.new_command;
					cmd_if.cmd_x <= on_wire.cmd[AX_X];
					cmd_if.cmd_y <= on_wire.cmd[AX_Y];
					cmd_if.cmd_yaw <= on_wire.cmd[AX_YAW];
					cmd_if.elapsed_us <= on_wire.elapsed_us;
					cmd_if.valid <= 1'b1;
					tx_gap <= pick_gap();
				end else begin
					cmd_if.valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Result monitor and receiver. Checks every accepted beat against the
	// oldest prediction; ready drops for random gaps and for the hold-off.
	// ---------------------------------------------------------------
	always @(posedge clk) begin : result_monitor
		motion_t got;
		if (!arst_n) begin
			res_if.ready <= 1'b0;
			rx_gap <= 0;
		end else begin
			if (res_if.valid && res_if.ready) begin
				got.vel[AX_X] = res_if.vel_x;
				got.vel[AX_Y] = res_if.vel_y;
				got.vel[AX_YAW] = res_if.vel_yaw;
				got.acc[AX_X] = res_if.acc_x;
				got.acc[AX_Y] = res_if.acc_y;
				got.acc[AX_YAW] = res_if.acc_yaw;
				got.sat[AX_X] = res_if.sat_x;
				got.sat[AX_Y] = res_if.sat_y;
				got.sat[AX_YAW] = res_if.sat_yaw;
				got.timed_out = res_if.timed_out;
				n_done++;
				if (expected_q.size() == 0) begin
					$error("result beat with no prediction waiting");
					n_err++;
				end else begin
					check_beat(expected_q.pop_front(), got);
				end
			end
			if (rx_gap != 0) begin
				rx_gap <= rx_gap - 1;
				res_if.ready <= 1'b0;
			end else begin
				res_if.ready <= !rx_hold;
				// stalls start after a beat or at any odd moment
				if ((res_if.valid && res_if.ready) || $urandom_range(0, 15) == 0)
					rx_gap <= pick_gap();
			end
		end
	end

	// Long receiver hold-off: the block fills and must stall its input.
	initial begin : receiver_hold
		wait (hold_go);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold <= 1'b0;
	end

	// Run limit, far above the slowest legal run.
	initial begin : watchdog
		#20_000_000;
		$display("tb_top: errors");
		$finish;
	end

	// Register write; the predictor copy follows at once since the block
	// is idle whenever this runs.
	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] d);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= d;
		case (idx)
			REG_MAX_VEL_X: lim_vel[AX_X] = d[LIM_W-1:0];
			REG_MAX_VEL_Y: lim_vel[AX_Y] = d[LIM_W-1:0];
			REG_MAX_VEL_YAW: lim_vel[AX_YAW] = d[LIM_W-1:0];
			REG_MAX_ACC_X: lim_acc[AX_X] = d[LIM_W-1:0];
			REG_MAX_ACC_Y: lim_acc[AX_Y] = d[LIM_W-1:0];
			REG_MAX_ACC_YAW: lim_acc[AX_YAW] = d[LIM_W-1:0];
			REG_TIMEOUT: tmo = d;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic queue_tick(input bit nc, input logic [VEL_W-1:0] x, y, yaw,
			input int unsigned dt);
		tick_t t;
		t.new_command = nc;
		t.cmd[AX_X] = x;
		t.cmd[AX_Y] = y;
		t.cmd[AX_YAW] = yaw;
		t.elapsed_us = DT_W'(dt);
		pending.insert(pending.size(), t);
		n_sent++;
	endtask

	task automatic wait_idle();
		while (n_done != n_sent)
			@(posedge clk);
	endtask

	// Tick length: mostly kHz-style periods, with the extremes mixed in.
	function automatic int unsigned pick_dt();
		case ($urandom_range(0, 15))
			0: return 1;
			1: return 1000000;
			2, 3: return $urandom_range(1, 1000000);
			4, 5: return $urandom_range(1, 100);
			default: return $urandom_range(200, 20000);
		endcase
	endfunction

	// Command word for an axis: rails, values around the clamp edge,
	// values inside the limit, or anything at all.
	function automatic logic [VEL_W-1:0] rand_cmd(input longint lim);
		longint v;
		case ($urandom_range(0, 9))
			0: v = 64'sh7FFF_FFFF;
			1: v = -64'sh8000_0000;
			2, 3: begin
				v = lim + longint'($urandom_range(0, 2)) - 1;
				if ($urandom_range(0, 1))
					v = -v;
			end
			4, 5, 6: v = longint'($urandom_range(0, 32'(2 * lim))) - lim;
			default: v = longint'($urandom);
		endcase
		return v[VEL_W-1:0];
	endfunction

	task automatic rand_config();
		logic [CFG_DATA_W-1:0] d;
		int i;
		for (i = 0; i < 2 * AXES; i++) begin
			case ($urandom_range(0, 7))
				0: d = '0;
				1: d = {1'($urandom_range(0, 1)), 31'h7FFF_FFFF};
				2, 3, 4: d = $urandom_range(1, 10 << 16);
				default: d = $urandom;
			endcase
			set_reg(REG_MAX_VEL_X + CFG_IDX_W'(i), d);
		end
		case ($urandom_range(0, 7))
			0: d = '0;
			1: d = '1;
			2, 3: d = $urandom_range(1, 5000);
			4, 5, 6: d = $urandom_range(1000, 2000000);
			default: d = $urandom;
		endcase
		set_reg(REG_TIMEOUT, d);
		if ($urandom_range(0, 2) == 0)
			set_reg(REG_UNUSED, $urandom);
	endtask

	// Random traffic shaped like a control loop: runs of ticks at one
	// period, usually opened by a new command, with stray commands and
	// odd periods in between. Unused command words still carry noise.
	task automatic queue_random(input int n);
		int left, run, k, i;
		int unsigned period, dt;
		bit nc;
		logic [AXES-1:0][VEL_W-1:0] c;
		left = n;
		while (left > 0) begin
			run = $urandom_range(1, 12);
			period = pick_dt();
			for (k = 0; k < run && left > 0; k++) begin
				nc = (k == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 15) == 0);
				for (i = 0; i < AXES; i++)
					c[i] = nc ? rand_cmd(longint'(lim_vel[i])) : VEL_W'($urandom);
				dt = ($urandom_range(0, 3) == 0) ? pick_dt() : period;
				queue_tick(nc, c[AX_X], c[AX_Y], c[AX_YAW], dt);
				left--;
			end
		end
	endtask

	initial begin : stimulus
		int ph, i;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		cmd_if.valid = 1'b0;
		cmd_if.new_command = 1'b0;
		cmd_if.cmd_x = '0;
		cmd_if.cmd_y = '0;
		cmd_if.cmd_yaw = '0;
		cmd_if.elapsed_us = '0;
		res_if.ready = 1'b0;
		// predictor at reset: default limits, nothing held, timer all ones
		for (i = 0; i < AXES; i++) begin
			lim_vel[i] = VEL_LIM_RST;
			lim_acc[i] = ACC_LIM_RST;
		end
		tmo = TIMEOUT_RST;
		held_cmd = '0;
		prev_vel = '0;
		sat_flags = '0;
		since_cmd = '1;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Reset values: no command yet, so the timer saturates and every
		// tick is timed out.
		queue_tick(1'b0, $urandom, $urandom, $urandom, 1000);
		queue_tick(1'b0, $urandom, $urandom, $urandom, 1000000);
		wait_idle();

		// Rails on the x and y limits; timeout all ones so even the saturated timer
		// does not time out. Bit 31 of a limit write must be dropped.
		set_reg(REG_MAX_VEL_X, 32'hFFFF_FFFF);
		set_reg(REG_MAX_VEL_Y, 32'h0);
		set_reg(REG_MAX_VEL_YAW, 32'd100 << 16);
		set_reg(REG_MAX_ACC_X, 32'h7FFF_FFFF);
		set_reg(REG_MAX_ACC_Y, 32'h0);
		set_reg(REG_MAX_ACC_YAW, 32'd1 << 16);
		set_reg(REG_TIMEOUT, 32'hFFFF_FFFF);
		set_reg(REG_UNUSED, 32'h1234_5678);
		queue_tick(1'b0, $urandom, $urandom, $urandom, 1);
		queue_tick(1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1000000);
		// full-scale swing on x, shortest tick: rate far beyond the limit
		queue_tick(1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 32'd5, 1);
		queue_tick(1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 32'd5, 1000000);
		queue_tick(1'b0, $urandom, $urandom, $urandom, 20'h7FFFF);
		wait_idle();

		// Timeout edge: a gap equal to the timeout still counts, one more
		// microsecond times out. Clamp edge: exactly -max is not clamped.
		set_reg(REG_MAX_VEL_X, 32'd3 << 16);
		set_reg(REG_MAX_VEL_Y, 32'd2 << 16);
		set_reg(REG_MAX_VEL_YAW, 32'd1 << 16);
		set_reg(REG_MAX_ACC_X, 32'd50 << 16);
		set_reg(REG_MAX_ACC_Y, 32'd50 << 16);
		set_reg(REG_MAX_ACC_YAW, 32'd50 << 16);
		set_reg(REG_TIMEOUT, 32'd1000);
		queue_tick(1'b1, 32'd5 << 16, -(32'd2 << 16), (32'd1 << 16) + 1, 300);
		queue_tick(1'b0, $urandom, $urandom, $urandom, 1000);
		queue_tick(1'b0, $urandom, $urandom, $urandom, 1);
		queue_tick(1'b0, $urandom, $urandom, $urandom, 20000);
		queue_tick(1'b1, 32'd0, 32'd0, 32'd0, 1);
		wait_idle();

		// Zero timeout: only a tick that brings a command is live.
		set_reg(REG_TIMEOUT, 32'd0);
		queue_tick(1'b1, 32'd1 << 16, -(32'd1 << 16), 32'd7, 5000);
		queue_tick(1'b0, $urandom, $urandom, $urandom, 1);

		// Random phases, each with its own limits. Phase 4 runs without
		// gaps; phase 2 carries the long receiver hold-off; phase 3 has
		// the sender wait for a full drain midway.
		for (ph = 0; ph < NUM_PHASES; ph++) begin
			wait_idle();
			@(posedge clk);
			idle_on <= (ph != 4);
			rand_config();
			if (ph == 3) begin
				queue_random(TICKS_PER_PHASE / 2);
				wait_idle();
				queue_random(TICKS_PER_PHASE - TICKS_PER_PHASE / 2);
			end else begin
				queue_random(TICKS_PER_PHASE);
				if (ph == 2)
					hold_go = 1'b1;
			end
		end

		wait_idle();
		repeat (40) @(posedge clk);
		if (expected_q.size() != 0) begin
			$error("%0d predicted results never arrived", expected_q.size());
			n_err++;
		end
		if (n_err == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule

FILE: sim.f
design/vcsl_pkg.sv
design/vcsl_if.sv
design/vcsl_div.sv
design/vcsl_lane.sv
design/velocity_command_slew_limiter.sv
bench/tb_top.sv
